// ----- src/x64e_pkg.sv -----
// Package: shared types and encoding constants for the x86-64 byte encoder.
`default_nettype none
package x64e_pkg;

  // Request kinds
  typedef enum logic [4:0] {
    OPC_MOV_R32_IMM  = 5'd0,
    OPC_MOV_R64_R64  = 5'd1,
    OPC_MOV_R32_R32  = 5'd2,
    OPC_LOAD32       = 5'd3,
    OPC_STORE32      = 5'd4,
    OPC_MOV_R64_IMM  = 5'd5,
    OPC_LEA64        = 5'd6,
    OPC_STORE32_IMM  = 5'd7,
    OPC_STORE8_IMM   = 5'd8,
    OPC_ALU_RR       = 5'd9,
    OPC_ALU_IMM      = 5'd10,
    OPC_PUSH         = 5'd11,
    OPC_POP          = 5'd12,
    OPC_RET          = 5'd13,
    OPC_CALL         = 5'd14,
    OPC_RAW_BYTE     = 5'd15,
    OPC_RESTART      = 5'd16
  } opcode_e;

  // Operand form after the opcode byte
  typedef enum logic [1:0] {
    FORM_NONE   = 2'd0,
    FORM_DIRECT = 2'd1,
    FORM_MEM    = 2'd2
  } form_e;

  localparam int unsigned MaxBytes   = 12;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned PosWidth   = 17;
  localparam int unsigned QueueDepth = 2;

  localparam logic [PosWidth-1:0] CapReset = 17'h10000;

  // Byte codes
  localparam logic [7:0] RexBase       = 8'h40;
  localparam logic [7:0] RexW          = 8'h08;
  localparam logic [7:0] ModrmDirect   = 8'hC0;
  localparam logic [7:0] SibNoIndex    = 8'h24;
  localparam logic [7:0] OpMovStore    = 8'h89;
  localparam logic [7:0] OpMovLoad     = 8'h8B;
  localparam logic [7:0] OpLea         = 8'h8D;
  localparam logic [7:0] OpMovMemImm32 = 8'hC7;
  localparam logic [7:0] OpMovMemImm8  = 8'hC6;
  localparam logic [7:0] OpAluImm32    = 8'h81;
  localparam logic [7:0] OpMovRegImm   = 8'hB8;
  localparam logic [7:0] OpPush        = 8'h50;
  localparam logic [7:0] OpPop         = 8'h58;
  localparam logic [7:0] OpRet         = 8'hC3;
  localparam logic [7:0] OpGroup5      = 8'hFF;
  localparam logic [2:0] ExtCall       = 3'd2;
  localparam logic [2:0] RmSib         = 3'd4;
  localparam logic [2:0] RmRbp         = 3'd5;
  localparam logic [1:0] ModNoDisp     = 2'd0;
  localparam logic [1:0] ModDisp8      = 2'd1;
  localparam logic [1:0] ModDisp32     = 2'd2;

  // One encoded instruction as queued between front and back
  typedef struct packed {
    logic                            restart;
    logic [CountWidth-1:0]           count;
    logic [MaxBytes-1:0][7:0]        code_bytes;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/x64e_if.sv -----
// Interfaces: instruction request channel and encoded byte channel.
`default_nettype none
interface x64e_req_if;
  logic               valid;
  logic               ready;
  logic [4:0]         opcode;
  logic [3:0]         reg_operand;
  logic [3:0]         rm_operand;
  logic [2:0]         alu_op;
  logic signed [31:0] displacement;
  logic [63:0]        immediate;

  modport source (output valid, opcode, reg_operand, rm_operand, alu_op, displacement,
                  immediate, input ready);
  modport sink   (input valid, opcode, reg_operand, rm_operand, alu_op, displacement,
                  immediate, output ready);
endinterface

interface x64e_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_byte;
  logic        has_byte;
  logic        kept;
  logic [16:0] position;
  logic        last;
  logic        overflow;

  modport source (output valid, code_byte, has_byte, kept, position, last, overflow,
                  input ready);
  modport sink   (input valid, code_byte, has_byte, kept, position, last, overflow,
                  output ready);
endinterface
`default_nettype wire

// ----- src/x64e_front.sv -----
// Front end: accepts requests and encodes each known one into a queued byte list.
`default_nettype none
module x64e_front (
  x64e_req_if.sink          req_i,
  input  wire logic         full_i,
  output x64e_pkg::entry_t  entry_o,
  output logic              push_o
);

  logic                 rex_en;
  logic                 rex_w;
  logic                 rex_r;
  logic [7:0]           op_byte;
  x64e_pkg::form_e      form;
  logic [2:0]           mreg;
  logic [3:0]           imm_len;
  logic                 known;
  logic                 restart;
  logic [7:0]           rex_byte;
  logic [1:0]           mod_bits;
  logic [2:0]           rm7;
  logic [2:0]           reg7;
  logic [31:0]          disp;
  logic [x64e_pkg::CountWidth-1:0] n;
  x64e_pkg::entry_t     e;

  assign rm7  = req_i.rm_operand[2:0];
  assign reg7 = req_i.reg_operand[2:0];
  assign disp = req_i.displacement;

  // Stall only on a full queue
  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i && known;
  assign entry_o     = e;

  // Classify the request
  always_comb begin
    rex_en  = 1'b1;
    rex_w   = 1'b0;
    rex_r   = 1'b0;
    op_byte = x64e_pkg::OpMovStore;
    form    = x64e_pkg::FORM_NONE;
    mreg    = reg7;
    imm_len = 4'd0;
    known   = 1'b1;
    restart = 1'b0;
    unique case (req_i.opcode)
      x64e_pkg::OPC_MOV_R32_IMM: begin
        op_byte = x64e_pkg::OpMovRegImm | {5'd0, rm7};
        imm_len = 4'd4;
      end
      x64e_pkg::OPC_MOV_R64_R64: begin
        rex_w = 1'b1;
        rex_r = req_i.reg_operand[3];
        form  = x64e_pkg::FORM_DIRECT;
      end
      x64e_pkg::OPC_MOV_R32_R32: begin
        rex_r = req_i.reg_operand[3];
        form  = x64e_pkg::FORM_DIRECT;
      end
      x64e_pkg::OPC_LOAD32: begin
        rex_r   = req_i.reg_operand[3];
        op_byte = x64e_pkg::OpMovLoad;
        form    = x64e_pkg::FORM_MEM;
      end
      x64e_pkg::OPC_STORE32: begin
        rex_r = req_i.reg_operand[3];
        form  = x64e_pkg::FORM_MEM;
      end
      x64e_pkg::OPC_MOV_R64_IMM: begin
        rex_w   = 1'b1;
        op_byte = x64e_pkg::OpMovRegImm | {5'd0, rm7};
        imm_len = 4'd8;
      end
      x64e_pkg::OPC_LEA64: begin
        rex_w   = 1'b1;
        rex_r   = req_i.reg_operand[3];
        op_byte = x64e_pkg::OpLea;
        form    = x64e_pkg::FORM_MEM;
      end
      x64e_pkg::OPC_STORE32_IMM: begin
        op_byte = x64e_pkg::OpMovMemImm32;
        form    = x64e_pkg::FORM_MEM;
        mreg    = 3'd0;
        imm_len = 4'd4;
      end
      x64e_pkg::OPC_STORE8_IMM: begin
        op_byte = x64e_pkg::OpMovMemImm8;
        form    = x64e_pkg::FORM_MEM;
        mreg    = 3'd0;
        imm_len = 4'd1;
      end
      x64e_pkg::OPC_ALU_RR: begin
        rex_r   = req_i.reg_operand[3];
        op_byte = {2'b00, req_i.alu_op, 3'b001};
        form    = x64e_pkg::FORM_DIRECT;
      end
      x64e_pkg::OPC_ALU_IMM: begin
        op_byte = x64e_pkg::OpAluImm32;
        form    = x64e_pkg::FORM_DIRECT;
        mreg    = req_i.alu_op;
        imm_len = 4'd4;
      end
      x64e_pkg::OPC_PUSH: begin
        op_byte = x64e_pkg::OpPush | {5'd0, rm7};
      end
      x64e_pkg::OPC_POP: begin
        op_byte = x64e_pkg::OpPop | {5'd0, rm7};
      end
      x64e_pkg::OPC_RET: begin
        rex_en  = 1'b0;
        op_byte = x64e_pkg::OpRet;
      end
      x64e_pkg::OPC_CALL: begin
        op_byte = x64e_pkg::OpGroup5;
        form    = x64e_pkg::FORM_DIRECT;
        mreg    = x64e_pkg::ExtCall;
      end
      x64e_pkg::OPC_RAW_BYTE: begin
        rex_en  = 1'b0;
        op_byte = req_i.immediate[7:0];
      end
      x64e_pkg::OPC_RESTART: begin
        rex_en  = 1'b0;
        restart = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // REX byte and memory mod selection
  assign rex_byte = x64e_pkg::RexBase | (rex_w ? x64e_pkg::RexW : 8'h00) |
                    {5'd0, rex_r, 1'b0, req_i.rm_operand[3]};

  always_comb begin
    if (disp == 32'd0 && rm7 != x64e_pkg::RmRbp) begin
      mod_bits = x64e_pkg::ModNoDisp;
    end else if (&disp[31:7] || ~|disp[31:7]) begin
      mod_bits = x64e_pkg::ModDisp8;
    end else begin
      mod_bits = x64e_pkg::ModDisp32;
    end
  end

  // Lay the bytes out in emission order
  always_comb begin
    e            = '0;
    n            = '0;
    e.restart    = restart;
    if (restart) begin
      n = 4'd1;
    end else begin
      if (rex_en && rex_byte != x64e_pkg::RexBase) begin
        e.code_bytes[n] = rex_byte;
        n = n + 4'd1;
      end
      e.code_bytes[n] = op_byte;
      n = n + 4'd1;
      if (form == x64e_pkg::FORM_DIRECT) begin
        e.code_bytes[n] = x64e_pkg::ModrmDirect | {2'b00, mreg, rm7};
        n = n + 4'd1;
      end else if (form == x64e_pkg::FORM_MEM) begin
        e.code_bytes[n] = {mod_bits, mreg, rm7};
        n = n + 4'd1;
        if (rm7 == x64e_pkg::RmSib) begin
          e.code_bytes[n] = x64e_pkg::SibNoIndex;
          n = n + 4'd1;
        end
        if (mod_bits == x64e_pkg::ModDisp8) begin
          e.code_bytes[n] = disp[7:0];
          n = n + 4'd1;
        end else if (mod_bits == x64e_pkg::ModDisp32) begin
          for (int k = 0; k < 4; k++) begin
            e.code_bytes[n] = disp[8*k +: 8];
            n = n + 4'd1;
          end
        end
      end
      // Immediate, little-endian
      for (int k = 0; k < 8; k++) begin
        if (4'(k) < imm_len) begin
          e.code_bytes[n] = req_i.immediate[8*k +: 8];
          n = n + 4'd1;
        end
      end
    end
    e.count = n;
  end

endmodule
`default_nettype wire

// ----- src/x64e_queue.sv -----
// Short queue of encoded instructions between front and back.
`default_nettype none
module x64e_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire x64e_pkg::entry_t  entry_i,
  input  wire logic              pop_i,
  output x64e_pkg::entry_t       head_o,
  output logic                   full_o,
  output logic                   empty_o
);

  localparam int unsigned PtrWidth = $clog2(x64e_pkg::QueueDepth);

  x64e_pkg::entry_t     mem_q [x64e_pkg::QueueDepth];
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrWidth:0]    fill_q, fill_d;

  assign full_o  = (fill_q == (PtrWidth+1)'(x64e_pkg::QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(x64e_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(x64e_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/x64e_back.sv -----
// Back end: emits queued bytes one per cycle unless the output stalls, tracks position and overflow.
`default_nettype none
module x64e_back #(
  parameter longint unsigned MAX_CAPACITY = 64'd65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [16:0]       cfg_wdata_i,
  input  wire x64e_pkg::entry_t  head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  x64e_res_if.source             res_o
);

  localparam int unsigned PW = x64e_pkg::PosWidth;
  localparam logic [PW-1:0] CapLimit =
    (MAX_CAPACITY > ((64'd1 << PW) - 64'd1)) ? {PW{1'b1}} : PW'(MAX_CAPACITY);

  logic [PW-1:0]                   cap_q;
  logic [PW-1:0]                   cap_eff;
  logic [PW-1:0]                   pos_q, pos_d;
  logic                            ovf_q, ovf_d;
  logic [x64e_pkg::CountWidth-1:0] idx_q, idx_d;
  logic                            advance;
  logic                            take;
  logic                            is_last;

  logic          out_valid_q;
  logic [7:0]    byte_q, byte_d;
  logic          has_q, has_d;
  logic          kept_q, kept_d;
  logic [PW-1:0] opos_q, opos_d;
  logic          last_q;
  logic          oovf_q;

  assign cap_eff = (cap_q < CapLimit) ? cap_q : CapLimit;
  assign advance = !out_valid_q || res_o.ready;
  assign take    = advance && !empty_i;
  assign is_last = (idx_q == head_i.count - 1'b1);
  assign pop_o   = take && is_last;

  // Per-byte capacity check
  always_comb begin
    pos_d  = pos_q;
    ovf_d  = ovf_q;
    byte_d = head_i.code_bytes[idx_q];
    has_d  = 1'b1;
    kept_d = 1'b0;
    opos_d = pos_q;
    idx_d  = idx_q;
    if (head_i.restart) begin
      pos_d  = '0;
      ovf_d  = 1'b0;
      byte_d = '0;
      has_d  = 1'b0;
      opos_d = '0;
    end else if (!ovf_q) begin
      if (pos_q >= cap_eff) begin
        ovf_d = 1'b1;
      end else begin
        kept_d = 1'b1;
        pos_d  = pos_q + 1'b1;
      end
    end
    if (take) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= x64e_pkg::CapReset;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      idx_q <= idx_d;
      if (take) begin
        pos_q <= pos_d;
        ovf_q <= ovf_d;
      end
      if (advance) begin
        out_valid_q <= take;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_d;
      has_q  <= has_d;
      kept_q <= kept_d;
      opos_q <= opos_d;
      last_q <= is_last;
      oovf_q <= ovf_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.code_byte = byte_q;
  assign res_o.has_byte  = has_q;
  assign res_o.kept      = kept_q;
  assign res_o.position  = opos_q;
  assign res_o.last      = last_q;
  assign res_o.overflow  = oovf_q;

endmodule
`default_nettype wire

// ----- src/x64_instruction_byte_encoder.sv -----
// Top level: x86-64 instruction byte encoder.
//
//   Port          Dir   Kind               Payload
//   req_i         in    valid/ready        opcode, reg_operand, rm_operand, alu_op,
//                                          displacement, immediate
//   res_o         out   valid/ready        code_byte, has_byte, kept, position, last,
//                                          overflow
//   cfg_*_i       in    write enable/data  buffer_capacity (17 bits)
//
// The front encodes a request combinationally into a two-entry queue; the back
// emits one byte per cycle unless the output stalls: one result per encoded
// byte (1 to 12) or one for a restart; unknown opcodes leave no trace. The
// first result passes the queue, then the back's output register. Reset clears
// position, overflow and queue; capacity resets to 65536. Requests stall only
// while the queue is full; output stalls back up through the queue.
`default_nettype none
module x64_instruction_byte_encoder #(
  parameter longint unsigned MAX_CAPACITY = 64'd65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  x64e_req_if.sink         req_i,
  x64e_res_if.source       res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i
);

  x64e_pkg::entry_t entry;
  x64e_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  x64e_front u_front (
    .req_i   (req_i),
    .full_i  (full),
    .entry_o (entry),
    .push_o  (push)
  );

  x64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  x64e_back #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for the x86-64 instruction byte encoder: table-driven and random requests.
`timescale 1ns / 100ps

module tb;

  // Encoding bytes as the predictor sees them
  localparam logic [7:0]  ByteRex        = 8'h40;
  localparam logic [7:0]  ByteRexW       = 8'h08;
  localparam logic [7:0]  ByteRexB       = 8'h41;
  localparam logic [7:0]  ByteDirect     = 8'hC0;
  localparam logic [7:0]  ByteSib        = 8'h24;
  localparam logic [7:0]  ByteMovStore   = 8'h89;
  localparam logic [7:0]  ByteMovLoad    = 8'h8B;
  localparam logic [7:0]  ByteLea        = 8'h8D;
  localparam logic [7:0]  ByteStoreImm32 = 8'hC7;
  localparam logic [7:0]  ByteStoreImm8  = 8'hC6;
  localparam logic [7:0]  ByteAluImm     = 8'h81;
  localparam logic [7:0]  ByteMovRegImm  = 8'hB8;
  localparam logic [7:0]  BytePush       = 8'h50;
  localparam logic [7:0]  BytePop        = 8'h58;
  localparam logic [7:0]  ByteRet        = 8'hC3;
  localparam logic [7:0]  ByteGroup5     = 8'hFF;
  localparam logic [7:0]  ByteCallModrm  = 8'hD0;
  localparam logic [1:0]  ModNone        = 2'd0;
  localparam logic [1:0]  ModByte        = 2'd1;
  localparam logic [1:0]  ModDword       = 2'd2;
  localparam logic [2:0]  RmNeedsSib     = 3'd4;
  localparam logic [2:0]  RmNeedsDisp    = 3'd5;
  localparam logic [16:0] MaxCapacity    = 17'h10000;
  localparam logic [16:0] CapAfterReset  = 17'h10000;
  localparam logic [16:0] CapWidest      = 17'h1FFFF;
  localparam logic [4:0]  OpcUnusedLow   = 5'd17;
  localparam logic [4:0]  OpcUnusedHigh  = 5'd31;
  localparam int          NumRows        = 25;
  localparam int          NumPhases      = 7;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [3:0]  reg_op;
    logic [3:0]  rm_op;
    logic [2:0]  alu;
    logic [31:0] disp;
    logic [63:0] imm;
  } req_t;

  // n_typed bytes of typed are the expected code, first byte in typed[7:0]
  typedef struct packed {
    req_t        req;
    logic [2:0]  n_typed;
    logic [31:0] typed;
  } row_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic        has_byte;
    logic        kept;
    logic [16:0] position;
    logic        last;
    logic        overflow;
  } byte_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [16:0] cfg_wdata_i;

  x64e_req_if req_if ();
  x64e_res_if res_if ();

  x64_instruction_byte_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state
  logic [16:0] cap_reg  = CapAfterReset;
  logic [16:0] wr_pos   = '0;
  logic        ovf_flag = 1'b0;
  logic [7:0]  code_seq [$];
  byte_res_t   pending_bytes [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  // Directed requests: boundaries, every kind, every addressing special case
  row_t dir_rows [NumRows] = '{
    '{'{x64e_pkg::OPC_RESTART, 4'd0, 4'd0, 3'd0, 32'h0, 64'h0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_RET, 4'd0, 4'd0, 3'd0, 32'h0, 64'h0},
      3'd1, 32'hC3},
    '{'{x64e_pkg::OPC_RAW_BYTE, 4'd0, 4'd0, 3'd0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF},
      3'd1, 32'hFF},
    '{'{x64e_pkg::OPC_RAW_BYTE, 4'd15, 4'd15, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00},
      3'd1, 32'h00},
    '{'{x64e_pkg::OPC_PUSH, 4'd0, 4'd0, 3'd0, 32'h0, 64'h0},
      3'd1, 32'h50},
    '{'{x64e_pkg::OPC_POP, 4'd0, 4'd15, 3'd0, 32'h0, 64'h0},
      3'd2, 32'h5F41},
    '{'{x64e_pkg::OPC_CALL, 4'd0, 4'd8, 3'd0, 32'h0, 64'h0},
      3'd3, 32'hD0FF41},
    '{'{x64e_pkg::OPC_CALL, 4'd0, 4'd7, 3'd0, 32'h0, 64'h0},
      3'd2, 32'hD7FF},
    '{'{x64e_pkg::OPC_MOV_R64_R64, 4'd0, 4'd0, 3'd0, 32'h0, 64'h0},
      3'd3, 32'hC08948},
    '{'{x64e_pkg::OPC_MOV_R32_R32, 4'd15, 4'd15, 3'd0, 32'h0, 64'h0},
      3'd3, 32'hFF8945},
    '{'{x64e_pkg::OPC_ALU_RR, 4'd15, 4'd0, 3'd7, 32'h0, 64'h0},
      3'd3, 32'hF83944},
    '{'{x64e_pkg::OPC_MOV_R32_IMM, 4'd0, 4'd9, 3'd0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_MOV_R64_IMM, 4'd0, 4'd0, 3'd0, 32'h0, 64'h8000_0000_0000_0001},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_LOAD32, 4'd3, 4'd4, 3'd0, 32'h0, 64'h0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_STORE32, 4'd2, 4'd5, 3'd0, 32'h0, 64'h0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_STORE32, 4'd8, 4'd13, 3'd0, 32'd127, 64'h0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_LEA64, 4'd1, 4'd12, 3'd0, 32'd128, 64'h0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_LOAD32, 4'd14, 4'd6, 3'd0, 32'hFFFF_FF80, 64'h0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_LOAD32, 4'd9, 4'd0, 3'd0, 32'hFFFF_FF7F, 64'h0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_STORE32_IMM, 4'd0, 4'd4, 3'd0, 32'h7FFF_FFFF, 64'h0000_0000_FFFF_FFFF},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_STORE8_IMM, 4'd0, 4'd12, 3'd0, 32'h8000_0000, 64'h0000_0000_0000_00AB},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_ALU_IMM, 4'd0, 4'd11, 3'd0, 32'h0, 64'h1234_5678_9ABC_DEF0},
      3'd0, 32'h0},
    '{'{x64e_pkg::OPC_ALU_IMM, 4'd0, 4'd2, 3'd5, 32'h0, 64'h0000_0000_8000_0000},
      3'd0, 32'h0},
    '{'{OpcUnusedLow, 4'd0, 4'd0, 3'd0, 32'h0, 64'h0},
      3'd0, 32'h0},
    '{'{OpcUnusedHigh, 4'd15, 4'd15, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
      3'd0, 32'h0}
  };

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Byte encoding of one request into code_seq
  function automatic void emit(input logic [7:0] b);
    code_seq.push_back(b);
  endfunction

  function automatic void emit_dword(input logic [31:0] v);
    emit(v[7:0]);
    emit(v[15:8]);
    emit(v[23:16]);
    emit(v[31:24]);
  endfunction

  function automatic void emit_rex(input logic w, input logic [3:0] r, input logic [3:0] b);
    logic [7:0] v;
    v = ByteRex | (w ? ByteRexW : 8'h00) | {5'b0, r[3], 1'b0, b[3]};
    if (v != ByteRex) emit(v);
  endfunction

  function automatic void emit_direct(input logic [3:0] r, input logic [3:0] m);
    emit(ByteDirect | {2'b00, r[2:0], m[2:0]});
  endfunction

  // [base+disp]: mod by displacement range, SIB for rsp/r12, disp8 forced for rbp/r13
  function automatic void emit_memory(input logic [3:0] r, input logic [3:0] base,
                                      input logic [31:0] disp);
    logic [1:0] md;
    if (disp == 32'h0 && base[2:0] != RmNeedsDisp) md = ModNone;
    else if ($signed(disp) >= -128 && $signed(disp) <= 127) md = ModByte;
    else md = ModDword;
    emit({md, r[2:0], base[2:0]});
    if (base[2:0] == RmNeedsSib) emit(ByteSib);
    if (md == ModByte) emit(disp[7:0]);
    else if (md == ModDword) emit_dword(disp);
  endfunction

  function automatic void encode_instruction(input req_t r);
    code_seq.delete();
    case (r.opcode)
      x64e_pkg::OPC_MOV_R32_IMM: begin
        emit_rex(1'b0, 4'd0, r.rm_op);
        emit(ByteMovRegImm + {5'b0, r.rm_op[2:0]});
        emit_dword(r.imm[31:0]);
      end
      x64e_pkg::OPC_MOV_R64_R64: begin
        emit_rex(1'b1, r.reg_op, r.rm_op);
        emit(ByteMovStore);
        emit_direct(r.reg_op, r.rm_op);
      end
      x64e_pkg::OPC_MOV_R32_R32: begin
        emit_rex(1'b0, r.reg_op, r.rm_op);
        emit(ByteMovStore);
        emit_direct(r.reg_op, r.rm_op);
      end
      x64e_pkg::OPC_LOAD32: begin
        emit_rex(1'b0, r.reg_op, r.rm_op);
        emit(ByteMovLoad);
        emit_memory(r.reg_op, r.rm_op, r.disp);
      end
      x64e_pkg::OPC_STORE32: begin
        emit_rex(1'b0, r.reg_op, r.rm_op);
        emit(ByteMovStore);
        emit_memory(r.reg_op, r.rm_op, r.disp);
      end
      x64e_pkg::OPC_MOV_R64_IMM: begin
        emit_rex(1'b1, 4'd0, r.rm_op);
        emit(ByteMovRegImm + {5'b0, r.rm_op[2:0]});
        emit_dword(r.imm[31:0]);
        emit_dword(r.imm[63:32]);
      end
      x64e_pkg::OPC_LEA64: begin
        emit_rex(1'b1, r.reg_op, r.rm_op);
        emit(ByteLea);
        emit_memory(r.reg_op, r.rm_op, r.disp);
      end
      x64e_pkg::OPC_STORE32_IMM: begin
        emit_rex(1'b0, 4'd0, r.rm_op);
        emit(ByteStoreImm32);
        emit_memory(4'd0, r.rm_op, r.disp);
        emit_dword(r.imm[31:0]);
      end
      x64e_pkg::OPC_STORE8_IMM: begin
        emit_rex(1'b0, 4'd0, r.rm_op);
        emit(ByteStoreImm8);
        emit_memory(4'd0, r.rm_op, r.disp);
        emit(r.imm[7:0]);
      end
      x64e_pkg::OPC_ALU_RR: begin
        emit_rex(1'b0, r.reg_op, r.rm_op);
        emit({2'b00, r.alu, 3'b001});
        emit_direct(r.reg_op, r.rm_op);
      end
      x64e_pkg::OPC_ALU_IMM: begin
        emit_rex(1'b0, 4'd0, r.rm_op);
        emit(ByteAluImm);
        emit({2'b11, r.alu, r.rm_op[2:0]});
        emit_dword(r.imm[31:0]);
      end
      x64e_pkg::OPC_PUSH: begin
        if (r.rm_op[3]) emit(ByteRexB);
        emit(BytePush + {5'b0, r.rm_op[2:0]});
      end
      x64e_pkg::OPC_POP: begin
        if (r.rm_op[3]) emit(ByteRexB);
        emit(BytePop + {5'b0, r.rm_op[2:0]});
      end
      x64e_pkg::OPC_RET: emit(ByteRet);
      x64e_pkg::OPC_CALL: begin
        if (r.rm_op[3]) emit(ByteRexB);
        emit(ByteGroup5);
        emit(ByteCallModrm | {5'b0, r.rm_op[2:0]});
      end
      x64e_pkg::OPC_RAW_BYTE: emit(r.imm[7:0]);
      default: ;
    endcase
  endfunction

  // Expected results of one accepted request, with buffer placement and overflow
  task automatic predict_request(input req_t r, input logic [2:0] n_typed,
                                 input logic [31:0] typed);
    byte_res_t  e;
    logic [16:0] cap_eff;
    if (r.opcode == x64e_pkg::OPC_RESTART) begin
      wr_pos   = '0;
      ovf_flag = 1'b0;
      e = '{code_byte: 8'h00, has_byte: 1'b0, kept: 1'b0, position: 17'd0,
            last: 1'b1, overflow: 1'b0};
      pending_bytes.push_back(e);
    end else begin
      encode_instruction(r);
      if (n_typed != 3'd0) begin
        code_seq.delete();
        for (int i = 0; i < n_typed; i++) code_seq.push_back(typed[8*i +: 8]);
      end
      cap_eff = (cap_reg > MaxCapacity) ? MaxCapacity : cap_reg;
      foreach (code_seq[i]) begin
        e.code_byte = code_seq[i];
        e.has_byte  = 1'b1;
        e.kept      = 1'b0;
        e.position  = wr_pos;
        if (!ovf_flag) begin
          if (wr_pos >= cap_eff) begin
            ovf_flag = 1'b1;
          end else begin
            e.kept = 1'b1;
            wr_pos = wr_pos + 17'd1;
          end
        end
        e.last     = (i == code_seq.size() - 1);
        e.overflow = ovf_flag;
        pending_bytes.push_back(e);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("tb: mismatch in %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
  endtask

  task automatic check_result(input byte_res_t got);
    byte_res_t want;
    if (pending_bytes.size() == 0) begin
      report_mismatch("result with nothing pending", got.code_byte, 0);
    end else begin
      want = pending_bytes.pop_front();
      if (got.code_byte !== want.code_byte)
        report_mismatch("code_byte", got.code_byte, want.code_byte);
      if (got.has_byte !== want.has_byte)
        report_mismatch("has_byte", got.has_byte, want.has_byte);
      if (got.kept !== want.kept) report_mismatch("kept", got.kept, want.kept);
      if (got.position !== want.position)
        report_mismatch("position", got.position, want.position);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", got.overflow, want.overflow);
    end
  endtask

  // Sender pacing: bursts of random length, random gaps, sometimes long bursts
  task automatic pace_sender();
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Present one request, hold until accepted, then predict it
  task automatic push_request(input req_t r, input logic [2:0] n_typed,
                              input logic [31:0] typed);
    req_if.valid        <= 1'b1;
    req_if.opcode       <= r.opcode;
    req_if.reg_operand  <= r.reg_op;
    req_if.rm_operand   <= r.rm_op;
    req_if.alu_op       <= r.alu;
    req_if.displacement <= r.disp;
    req_if.immediate    <= r.imm;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_request(r, n_typed, typed);
    pace_sender();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Capacity write once the encoder is idle
  task automatic set_capacity(input logic [16:0] cap);
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg   = cap;
  endtask

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) r.opcode = 5'($urandom_range(OpcUnusedLow, OpcUnusedHigh));
    else if (pick < 13) r.opcode = x64e_pkg::OPC_RESTART;
    else r.opcode = 5'($urandom_range(x64e_pkg::OPC_MOV_R32_IMM, x64e_pkg::OPC_RAW_BYTE));
    r.reg_op = 4'($urandom_range(0, 15));
    r.rm_op  = 4'($urandom_range(0, 15));
    r.alu    = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: r.disp = 32'h0;
      1: r.disp = 32'($urandom_range(0, 255)) - 32'd128;
      2: begin
        case ($urandom_range(0, 3))
          0: r.disp = 32'd127;
          1: r.disp = 32'd128;
          2: r.disp = 32'hFFFF_FF80;
          default: r.disp = 32'hFFFF_FF7F;
        endcase
      end
      3: r.disp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: r.disp = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: r.imm = 64'h0;
      1: r.imm = '1;
      default: r.imm = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  // Result side: check accepted bytes, stall on a changing pattern
  initial begin
    byte_res_t   got;
    int unsigned cyc;
    int unsigned rx_mode;
    int unsigned rx_period;
    logic        rdy;
    res_if.ready = 1'b0;
    cyc       = 0;
    rx_mode   = 0;
    rx_period = 2;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got = '{code_byte: res_if.code_byte, has_byte: res_if.has_byte, kept: res_if.kept,
                position: res_if.position, last: res_if.last, overflow: res_if.overflow};
        check_result(got);
      end
      cyc++;
      if (cyc % 48 == 0) begin
        rx_mode   = $urandom_range(0, 3);
        rx_period = $urandom_range(2, 4);
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = (cyc % rx_period) == 0;
        2: rdy = $urandom_range(0, 9) < 6;
        default: rdy = (cyc % 12) < 6;
      endcase
      res_if.ready <= rdy;
    end
  end

  // Stimulus
  initial begin
    logic [16:0] phase_cap   [NumPhases];
    int unsigned phase_items [NumPhases];
    req_t        r;
    req_if.valid        = 1'b0;
    req_if.opcode       = '0;
    req_if.reg_operand  = '0;
    req_if.rm_operand   = '0;
    req_if.alu_op       = '0;
    req_if.displacement = '0;
    req_if.immediate    = '0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    rst_ni              = 1'b0;
    phase_cap   = '{17'd0, CapWidest, 17'($urandom_range(4, 60)), 17'($urandom_range(4, 60)),
                    17'd1, 17'($urandom_range(4, 60)), CapAfterReset};
    phase_items = '{6, 12, 15, 15, 8, 15, 14};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset capacity
    foreach (dir_rows[i]) push_request(dir_rows[i].req, dir_rows[i].n_typed, dir_rows[i].typed);

    // random phases, each opened by a restart under a new capacity
    for (int p = 0; p < NumPhases; p++) begin
      set_capacity(phase_cap[p]);
      r = random_request();
      r.opcode = x64e_pkg::OPC_RESTART;
      push_request(r, 3'd0, 32'h0);
      for (int k = 1; k < phase_items[p]; k++) push_request(random_request(), 3'd0, 32'h0);
    end

    req_if.valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
src/x64e_pkg.sv
src/x64e_if.sv
src/x64e_front.sv
src/x64e_queue.sv
src/x64e_back.sv
src/x64_instruction_byte_encoder.sv
bench/tb.sv
